[hw/rtl/vga_plane_pixel_serializer_assert.svh]
// Assertion macros for the pixel serializer.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef VGA_PLANE_PIXEL_SERIALIZER_ASSERT_SVH
`define VGA_PLANE_PIXEL_SERIALIZER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication.
`define VPPS_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vpps: same-cycle check failed");

// Next-cycle implication.
`define VPPS_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vpps: next-cycle check failed");

`else

`define VPPS_ASSERT_IMPL(name, ante, cons)
`define VPPS_ASSERT_NEXT(name, ante, cons)

`endif

`endif

[hw/rtl/vpps_pkg.sv]
`default_nettype none

package vpps_pkg;

	localparam int PLANES      = 4;
	localparam int BYTE_W      = 8;
	localparam int PIX_W       = 4;
	localparam int MODE_W      = 2;
	localparam int PIX_PER_GRP = 8;
	localparam int PIX_IDX_W   = $clog2(PIX_PER_GRP);
	localparam logic [PIX_IDX_W-1:0] LAST_PIX = PIX_IDX_W'(PIX_PER_GRP - 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Shift mode register values.
	localparam logic [MODE_W-1:0] SHIFT_PLANAR      = 2'd0;
	localparam logic [MODE_W-1:0] SHIFT_INTERLEAVED = 2'd1;
	localparam logic [MODE_W-1:0] SHIFT_PACKED      = 2'd2;
	localparam logic [MODE_W-1:0] SHIFT_PACKED_ALT  = 2'd3;

	// Decode kind attached to each queued group.
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_PLANAR      = 2'd0;
	localparam kind_t KIND_INTERLEAVED = 2'd1;
	localparam kind_t KIND_PACKED      = 2'd2;

	typedef logic [PLANES-1:0][BYTE_W-1:0] planes_t;

	typedef struct packed {
		kind_t   kind;
		planes_t planes;
	} q_entry_t;

endpackage

`default_nettype wire

[hw/rtl/vpps_grp_if.sv]
`default_nettype none

interface vpps_grp_if;
	logic       valid;
	logic       ready;
	logic [7:0] plane0_byte;
	logic [7:0] plane1_byte;
	logic [7:0] plane2_byte;
	logic [7:0] plane3_byte;

	modport source (
		output valid, plane0_byte, plane1_byte, plane2_byte, plane3_byte,
		input  ready
	);
	modport sink (
		input  valid, plane0_byte, plane1_byte, plane2_byte, plane3_byte,
		output ready
	);
endinterface

`default_nettype wire

[hw/rtl/vpps_pix_if.sv]
`default_nettype none

interface vpps_pix_if;
	logic       valid;
	logic       ready;
	logic [3:0] pixel_value;
	logic       last_pixel;

	modport source (
		output valid, pixel_value, last_pixel,
		input  ready
	);
	modport sink (
		input  valid, pixel_value, last_pixel,
		output ready
	);
endinterface

`default_nettype wire

[hw/rtl/vpps_cfg_if.sv]
`default_nettype none

interface vpps_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] shift_mode;

	modport source (
		output valid, shift_mode,
		input  ready
	);
	modport sink (
		input  valid, shift_mode,
		output ready
	);
endinterface

`default_nettype wire

[hw/rtl/vpps_front.sv]
`default_nettype none

module vpps_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	vpps_cfg_if.sink               cfg,
	vpps_grp_if.sink               grp,
	input  wire logic              q_full,
	output      logic              q_push,
	output      vpps_pkg::q_entry_t q_wr_entry
);
	import vpps_pkg::*;

	logic [MODE_W-1:0] mode_q;
	kind_t             kind;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= SHIFT_PLANAR;
		end else if (cfg.valid) begin
			mode_q <= cfg.shift_mode;
		end
	end

	// Both packed codes decode the same way, so they share one kind.
	always_comb begin
		if (mode_q == SHIFT_PLANAR) begin
			kind = KIND_PLANAR;
		end else if (mode_q == SHIFT_INTERLEAVED) begin
			kind = KIND_INTERLEAVED;
		end else if (mode_q inside {SHIFT_PACKED, SHIFT_PACKED_ALT}) begin
			kind = KIND_PACKED;
		end else begin
			kind = KIND_PLANAR;
		end
	end

	assign grp.ready = !q_full;
	assign q_push    = grp.valid && !q_full;

	assign q_wr_entry.kind   = kind;
	assign q_wr_entry.planes = {grp.plane3_byte, grp.plane2_byte,
	                            grp.plane1_byte, grp.plane0_byte};

endmodule

`default_nettype wire

[hw/rtl/vpps_queue.sv]
`default_nettype none

module vpps_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire vpps_pkg::q_entry_t wr_entry,
	input  wire logic               pop,
	output      logic               full,
	output      logic               rd_valid,
	output      vpps_pkg::q_entry_t rd_entry
);
	import vpps_pkg::*;

	q_entry_t          slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_entry = slots_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			next_ptr = '0;
		end else begin
			next_ptr = p + 1'b1;
		end
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/vpps_back.sv]
`default_nettype none

`include "vga_plane_pixel_serializer_assert.svh"

module vpps_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire vpps_pkg::q_entry_t q_entry,
	output      logic               q_pop,
	vpps_pix_if.source              pix
);
	import vpps_pkg::*;

	logic [PIX_IDX_W-1:0] cnt_q;
	logic                 out_vld_q;
	logic [PIX_W-1:0]     out_pix_q;
	logic                 out_last_q;
	logic                 load;

	function automatic logic [PIX_W-1:0] decode_pixel(input q_entry_t e,
	                                                  input logic [PIX_IDX_W-1:0] k);
		logic [2:0]        b;
		logic [2:0]        sh;
		logic              half;
		logic [BYTE_W-1:0] sel_byte;
		b        = ~k;
		sh       = {~k[1:0], 1'b0};
		half     = k[2];
		sel_byte = e.planes[k[2:1]];
		case (e.kind)
			KIND_PLANAR: begin
				decode_pixel = {e.planes[3][b], e.planes[2][b],
				                e.planes[1][b], e.planes[0][b]};
			end
			KIND_INTERLEAVED: begin
				decode_pixel = {e.planes[{1'b1, half}][sh +: 2],
				                e.planes[{1'b0, half}][sh +: 2]};
			end
			KIND_PACKED: begin
				decode_pixel = k[0] ? sel_byte[3:0] : sel_byte[7:4];
			end
			default: begin
				decode_pixel = '0;
			end
		endcase
	endfunction

	// A new pixel goes into the output register whenever the queue holds a group and the register is empty or drains.
	assign load  = q_valid && (!out_vld_q || pix.ready);
	assign q_pop = load && (cnt_q == LAST_PIX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (load) begin
				cnt_q     <= cnt_q + 1'b1;
				out_vld_q <= 1'b1;
			end else if (pix.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_pix_q  <= decode_pixel(q_entry, cnt_q);
			out_last_q <= (cnt_q == LAST_PIX);
		end
	end

	assign pix.valid       = out_vld_q;
	assign pix.pixel_value = out_pix_q;
	assign pix.last_pixel  = out_last_q;

	// A group stays at the queue head until all its pixels have been loaded into the output register.
	`VPPS_ASSERT_IMPL(a_head_held_mid_group, cnt_q != '0, q_valid)
	// Once the closing pixel of a group is on the port, the count has restarted.
	`VPPS_ASSERT_IMPL(a_last_restarts_count, pix.valid && pix.last_pixel, cnt_q == '0)
	// Loading the eighth pixel presents a marked beat on the next cycle.
	`VPPS_ASSERT_NEXT(a_last_marked, load && cnt_q == LAST_PIX, out_vld_q && out_last_q)

endmodule

`default_nettype wire

[hw/rtl/vga_plane_pixel_serializer.sv]
// Channel | Dir | Beat payload                          | Accepted when
// --------+-----+---------------------------------------+---------------------
// cfg     | in  | shift_mode[1:0]                       | cfg.valid & cfg.ready
// grp     | in  | plane0_byte..plane3_byte, 8 bits each | grp.valid & grp.ready
// pix     | out | pixel_value[3:0], last_pixel          | pix.valid & pix.ready
//
// Each group beat yields eight pixel beats, one per cycle unless pix.ready
// stalls the output register. An accepted group passes through a queue slot
// and then the output register before its first pixel beat appears, when
// the queue is empty and the output register is free or
// draining. The two-entry queue lets up to two groups wait while the output
// stalls. arst_n clears the shift mode to planar, empties the queue and drops
// pix.valid. cfg is always ready.
`default_nettype none

module vga_plane_pixel_serializer (
	input  wire logic  clk,
	input  wire logic  arst_n,
	vpps_cfg_if.sink   cfg,
	vpps_grp_if.sink   grp,
	vpps_pix_if.source pix
);
	import vpps_pkg::*;

	// Front: holds the shift mode register, tags each incoming group with its
	// decode kind and pushes it into the queue while there is room.
	logic     q_push;
	q_entry_t q_wr_entry;
	logic     q_full;

	// Back: walks the head group one pixel per cycle unless pix.ready stalls,
	// and pops it as the eighth pixel is loaded into the output register.
	logic     q_valid;
	q_entry_t q_rd_entry;
	logic     q_pop;

	vpps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.grp        (grp),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_wr_entry (q_wr_entry)
	);

	vpps_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr_entry),
		.pop      (q_pop),
		.full     (q_full),
		.rd_valid (q_valid),
		.rd_entry (q_rd_entry)
	);

	vpps_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_entry (q_rd_entry),
		.q_pop   (q_pop),
		.pix     (pix)
	);

endmodule

`default_nettype wire
